// ----- hdl/ssmmv_pkg.sv -----
`default_nettype none

package ssmmv_pkg;

  localparam int SAMPLE_BITS       = 16;
  localparam int MAX_COUNT_DEF     = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int COUNT_OUT_W       = 5;
  localparam int MEAN_W            = 32;
  localparam int VAR_W             = 46;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } sample_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic signed [SAMPLE_BITS-1:0] min_value;
    logic signed [MEAN_W-1:0]      mean_fixed;
    logic [VAR_W-1:0]              variance_fixed;
    logic [COUNT_OUT_W-1:0]        sample_count;
    logic                          overflow_error;
  } result_req_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_N_SQ,
    MUL_MAG_MAG,
    MUL_N_N
  } mul_sel_t;

  typedef enum logic [1:0] {
    D_HOLD,
    D_LOAD,
    D_SUB
  } d_op_t;

  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_LOAD_VAR,
    DIV_LOAD_MEAN,
    DIV_STEP
  } div_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_DONE
  } jmp_t;

  typedef struct packed {
    mul_sel_t mul;
    d_op_t    d_op;
    div_op_t  div_op;
    logic     save_var;
    jmp_t     jmp;
  } ucw_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
    ucw_t uw;
  } seq_ctl_t;

  localparam int PROG_LEN = 8;
  localparam int UPC_W    = 3;

  localparam ucw_t UCW_IDLE = '{MUL_NONE, D_HOLD, DIV_NONE, 1'b0, JMP_NEXT};

  // n*sumsq, sum^2, n*n, variance divide, mean divide, write result
  localparam ucw_t UCODE [PROG_LEN] = '{
    '{MUL_N_SQ,    D_HOLD, DIV_NONE,      1'b0, JMP_NEXT},
    '{MUL_MAG_MAG, D_LOAD, DIV_NONE,      1'b0, JMP_NEXT},
    '{MUL_N_N,     D_SUB,  DIV_NONE,      1'b0, JMP_NEXT},
    '{MUL_NONE,    D_HOLD, DIV_LOAD_VAR,  1'b0, JMP_NEXT},
    '{MUL_NONE,    D_HOLD, DIV_STEP,      1'b0, JMP_LOOP},
    '{MUL_NONE,    D_HOLD, DIV_LOAD_MEAN, 1'b1, JMP_NEXT},
    '{MUL_NONE,    D_HOLD, DIV_STEP,      1'b0, JMP_LOOP},
    '{MUL_NONE,    D_HOLD, DIV_NONE,      1'b0, JMP_DONE}
  };

endpackage

`default_nettype wire

// ----- hdl/ssmmv_div.sv -----
`default_nettype none

module ssmmv_div #(
  parameter int DW  = 2,
  parameter int DVW = 2,
  localparam int IW = $clog2(DW + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire logic           step,
  input  wire logic [DW-1:0]  load_quo,
  input  wire logic [DVW-1:0] load_dvs,
  input  wire logic [IW-1:0]  load_itr,
  output logic      [DW-1:0]  quo,
  output logic                rem_nz,
  output logic                last
);

  logic [DW-1:0]  quo_r, quo_nxt;
  logic [DVW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] dvs_r, dvs_nxt;
  logic [IW-1:0]  itr_r, itr_nxt;
  logic [DVW:0]   trial;
  logic [DVW:0]   diff;

  // restoring divide, one quotient bit per cycle while step is high
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    itr_nxt = itr_r;
    trial   = {rem_r, quo_r[DW-1]};
    diff    = trial - {1'b0, dvs_r};
    if (load) begin
      quo_nxt = load_quo;
      rem_nxt = '0;
      dvs_nxt = load_dvs;
      itr_nxt = load_itr;
    end else if (step) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DVW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      itr_nxt = itr_r - IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itr_r <= '0;
    end else begin
      itr_r <= itr_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quo    = quo_r;
  assign rem_nz = |rem_r;
  assign last   = (itr_r == IW'(1));

endmodule

`default_nettype wire

// ----- hdl/ssmmv_seq.sv -----
`default_nettype none

module ssmmv_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire ssmmv_pkg::seq_stat_t stat,
  output ssmmv_pkg::seq_ctl_t       ctl
);

  logic [ssmmv_pkg::UPC_W-1:0] upc_r, upc_nxt;
  logic                        busy_r, busy_nxt;
  ssmmv_pkg::ucw_t             uw;

  always_comb begin
    uw       = ssmmv_pkg::UCODE[upc_r];
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    ctl.busy = busy_r;
    ctl.done = 1'b0;
    ctl.uw   = busy_r ? uw : ssmmv_pkg::UCW_IDLE;
    if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = '0;
    end else if (busy_r) begin
      unique case (uw.jmp)
        ssmmv_pkg::JMP_NEXT: begin
          upc_nxt = upc_r + ssmmv_pkg::UPC_W'(1);
        end
        ssmmv_pkg::JMP_LOOP: begin
          if (stat.div_last) begin
            upc_nxt = upc_r + ssmmv_pkg::UPC_W'(1);
          end
        end
        ssmmv_pkg::JMP_DONE: begin
          if (stat.out_free) begin
            ctl.done = 1'b1;
            busy_nxt = 1'b0;
            upc_nxt  = '0;
          end
        end
        default: begin
          busy_nxt = 1'b0;
          upc_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sample_set_min_max_mean_variance.sv -----
// channel   direction  handshake              request type
// in_       input      in_valid / in_ready    ssmmv_pkg::sample_req_t
// out_      output     out_valid / out_ready  ssmmv_pkg::result_req_t
//
// samples are taken one per cycle while no set is being finished
// a request with last starts the microprogram, whose variance and mean divides produce DW and MW quotient bits,
//   DW = 2*CW + 2*SAMPLE_BITS - 1 + FRACTION_BITS and MW = CW + SAMPLE_BITS + FRACTION_BITS,
//   from the one-bit-per-cycle divider
// in_ready is low while the microprogram runs
// the result register holds a result while the next set accumulates; the final
//   step waits there if the previous result has not been taken
// synchronous reset clears the sequencer, the count, sum and square-sum accumulators, the overflow flag and out_valid
`default_nettype none

module sample_set_min_max_mean_variance #(
  parameter int MAX_COUNT     = ssmmv_pkg::MAX_COUNT_DEF,
  parameter int FRACTION_BITS = ssmmv_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire ssmmv_pkg::sample_req_t in_req,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output ssmmv_pkg::result_req_t      out_req
);

  localparam int SB   = ssmmv_pkg::SAMPLE_BITS;
  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int SW   = SB + CW;
  localparam int QW   = 2 * SB - 1 + CW;
  localparam int PW   = QW + SW;
  localparam int DDW  = CW + QW;
  localparam int DVW  = 2 * CW;
  localparam int DW   = DDW + FRACTION_BITS;
  localparam int MW   = SW + FRACTION_BITS;
  localparam int IW   = $clog2(DW + 1);
  localparam int VXW  = (DW > ssmmv_pkg::VAR_W) ? DW : ssmmv_pkg::VAR_W;
  localparam int MXW  = (MW + 1 > ssmmv_pkg::MEAN_W) ? MW + 1 : ssmmv_pkg::MEAN_W;
  localparam int OXW  = (CW > ssmmv_pkg::COUNT_OUT_W) ? CW : ssmmv_pkg::COUNT_OUT_W;

  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic signed [SB-1:0]   max_r, max_nxt;
  logic signed [SB-1:0]   min_r, min_nxt;
  logic signed [SW-1:0]   sum_r, sum_nxt;
  logic [QW-1:0]          sq_r, sq_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [PW-1:0]          p_r, p_nxt;
  logic [DDW-1:0]         d_r, d_nxt;
  logic [ssmmv_pkg::VAR_W-1:0] var_r, var_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ssmmv_pkg::result_req_t out_req_r, out_req_nxt;

  logic                   in_acc;
  logic                   start;
  logic signed [SB-1:0]   x;
  logic signed [2*SB-1:0] x_sq;
  logic [SW-1:0]          mag;
  logic [QW-1:0]          mul_a;
  logic [SW-1:0]          mul_b;
  logic                   div_load;
  logic                   div_step;
  logic [DW-1:0]          div_quo_in;
  logic [DVW-1:0]         div_dvs_in;
  logic [IW-1:0]          div_itr_in;
  logic [DW-1:0]          quo;
  logic                   rem_nz;
  logic                   div_last;
  logic [VXW-1:0]         var_x;
  logic [MXW-1:0]         mean_x;
  logic [OXW-1:0]         cnt_x;

  ssmmv_pkg::seq_stat_t   stat;
  ssmmv_pkg::seq_ctl_t    ctl;

  assign in_ready = !ctl.busy;
  assign in_acc   = in_valid && in_ready;
  assign start    = in_acc && in_req.last;
  assign x        = in_req.sample;
  assign x_sq     = x * x;
  assign mag      = sum_r[SW-1] ? (~sum_r + SW'(1)) : sum_r;

  assign stat.div_last = div_last;
  assign stat.out_free = !out_valid_r || out_ready;

  ssmmv_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctl   (ctl)
  );

  ssmmv_div #(
    .DW  (DW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .step     (div_step),
    .load_quo (div_quo_in),
    .load_dvs (div_dvs_in),
    .load_itr (div_itr_in),
    .quo      (quo),
    .rem_nz   (rem_nz),
    .last     (div_last)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.uw.mul)
      ssmmv_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      ssmmv_pkg::MUL_N_SQ: begin
        mul_a = sq_r;
        mul_b = SW'(cnt_r);
      end
      ssmmv_pkg::MUL_MAG_MAG: begin
        mul_a = QW'(mag);
        mul_b = mag;
      end
      ssmmv_pkg::MUL_N_N: begin
        mul_a = QW'(cnt_r);
        mul_b = SW'(cnt_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider load select
  always_comb begin
    div_load   = 1'b0;
    div_step   = 1'b0;
    div_quo_in = '0;
    div_dvs_in = '0;
    div_itr_in = '0;
    unique case (ctl.uw.div_op)
      ssmmv_pkg::DIV_NONE: begin
        div_load = 1'b0;
      end
      ssmmv_pkg::DIV_LOAD_VAR: begin
        div_load   = 1'b1;
        div_quo_in = DW'(d_r) << FRACTION_BITS;
        div_dvs_in = p_r[DVW-1:0];
        div_itr_in = IW'(DW);
      end
      ssmmv_pkg::DIV_LOAD_MEAN: begin
        div_load   = 1'b1;
        div_quo_in = DW'(mag) << (DW - SW);
        div_dvs_in = DVW'(cnt_r);
        div_itr_in = IW'(MW);
      end
      ssmmv_pkg::DIV_STEP: begin
        div_step = 1'b1;
      end
      default: begin
        div_load = 1'b0;
      end
    endcase
  end

  assign var_x  = VXW'(quo);
  assign mean_x = sum_r[SW-1] ? (MXW'(0) - (MXW'(quo[MW-1:0]) + MXW'(rem_nz)))
                              : MXW'(quo[MW-1:0]);
  assign cnt_x  = OXW'(cnt_r);

  always_comb begin
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    ovf_nxt       = ovf_r;
    p_nxt         = p_r;
    d_nxt         = d_r;
    var_nxt       = var_r;
    out_valid_nxt = out_valid_r;
    out_req_nxt   = out_req_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // accumulate
    if (in_acc) begin
      if (cnt_r < CW'(MAX_COUNT)) begin
        if (cnt_r == '0) begin
          max_nxt = x;
          min_nxt = x;
        end else begin
          if (x > max_r) begin
            max_nxt = x;
          end
          if (x < min_r) begin
            min_nxt = x;
          end
        end
        sum_nxt = sum_r + SW'(x);
        sq_nxt  = sq_r + QW'($unsigned(x_sq));
        cnt_nxt = cnt_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (ctl.uw.mul != ssmmv_pkg::MUL_NONE) begin
      p_nxt = PW'(mul_a) * PW'(mul_b);
    end

    unique case (ctl.uw.d_op)
      ssmmv_pkg::D_HOLD: d_nxt = d_r;
      ssmmv_pkg::D_LOAD: d_nxt = p_r[DDW-1:0];
      ssmmv_pkg::D_SUB:  d_nxt = d_r - p_r[DDW-1:0];
      default:           d_nxt = d_r;
    endcase

    if (ctl.uw.save_var) begin
      var_nxt = var_x[ssmmv_pkg::VAR_W-1:0];
    end

    if (ctl.done) begin
      out_valid_nxt              = 1'b1;
      out_req_nxt.max_value      = max_r;
      out_req_nxt.min_value      = min_r;
      out_req_nxt.mean_fixed     = mean_x[ssmmv_pkg::MEAN_W-1:0];
      out_req_nxt.variance_fixed = var_r;
      out_req_nxt.sample_count   = cnt_x[ssmmv_pkg::COUNT_OUT_W-1:0];
      out_req_nxt.overflow_error = ovf_r;
      cnt_nxt = '0;
      max_nxt = '0;
      min_nxt = '0;
      sum_nxt = '0;
      sq_nxt  = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    max_r     <= max_nxt;
    min_r     <= min_nxt;
    p_r       <= p_nxt;
    d_r       <= d_nxt;
    var_r     <= var_nxt;
    out_req_r <= out_req_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

`default_nettype wire

// ----- hdl/ssmmv_chk.sv -----
`default_nettype none

module ssmmv_chk (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire ssmmv_pkg::sample_req_t in_req,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire ssmmv_pkg::result_req_t out_req
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_req))
    else $error("result changed while stalled");

  // a closing sample blocks intake while the set is finished
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req.last |=> !in_ready)
    else $error("input taken right after a closing sample");

  a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_req.max_value >= out_req.min_value)
    else $error("max below min");

  // constant set has zero variance
  a_flat_var: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req.max_value == out_req.min_value |-> out_req.variance_fixed == '0)
    else $error("nonzero variance for a constant set");

endmodule

bind sample_set_min_max_mean_variance ssmmv_chk u_chk (.*);

`default_nettype wire

// ----- dv/sample_set_min_max_mean_variance_checker.sv -----
module sample_set_min_max_mean_variance_checker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  ssmmv_pkg::sample_req_t in_req,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  ssmmv_pkg::result_req_t out_req,
  output int                    error_count,
  output int                    results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ssmmv_pkg::COUNT_OUT_W-1:0] set_count;
  logic signed [15:0]                set_max;
  logic signed [15:0]                set_min;
  logic signed [20:0]                set_sum;
  logic [34:0]                       set_sum_sq;
  logic                              set_dropped;
  ssmmv_pkg::result_req_t            stats_due[$];

  initial error_count = 0;

  task automatic clear_set();
    set_count   = '0;
    set_max     = '0;
    set_min     = '0;
    set_sum     = '0;
    set_sum_sq  = '0;
    set_dropped = 1'b0;
  endtask

  function automatic ssmmv_pkg::result_req_t set_statistics();
    ssmmv_pkg::result_req_t stats;
    longint signed     scaled_sum;
    longint signed     n_signed;
    longint signed     mean_q;
    longint unsigned   n;
    longint unsigned   mag;
    longint unsigned   spread;
    longint unsigned   var_q;
    n          = longint'(set_count);
    n_signed   = longint'(set_count);
    scaled_sum = longint'(set_sum) * (64'sd1 <<< ssmmv_pkg::FRACTION_BITS_DEF);
    mean_q     = scaled_sum / n_signed;
    // round toward minus infinity
    if (scaled_sum < 0 && (scaled_sum % n_signed) != 0) mean_q = mean_q - 1;
    mag    = (set_sum < 0) ? longint'(-longint'(set_sum)) : longint'(set_sum);
    spread = n * longint'(set_sum_sq) - mag * mag;
    var_q  = (spread << ssmmv_pkg::FRACTION_BITS_DEF) / (n * n);
    stats.max_value      = set_max;
    stats.min_value      = set_min;
    stats.mean_fixed     = mean_q[ssmmv_pkg::MEAN_W-1:0];
    stats.variance_fixed = var_q[ssmmv_pkg::VAR_W-1:0];
    stats.sample_count   = set_count;
    stats.overflow_error = set_dropped;
    return stats;
  endfunction

  task automatic absorb_sample(input ssmmv_pkg::sample_req_t req);
    int square;
    square = int'(req.sample) * int'(req.sample);
    if (set_count < ssmmv_pkg::MAX_COUNT_DEF) begin
      if (set_count == 0) begin
        set_max = req.sample;
        set_min = req.sample;
      end else begin
        if (req.sample > set_max) set_max = req.sample;
        if (req.sample < set_min) set_min = req.sample;
      end
      set_sum    = set_sum + 21'(req.sample);
      set_sum_sq = set_sum_sq + 35'(square);
      set_count  = set_count + 1'b1;
    end else begin
      set_dropped = 1'b1;
    end
    if (req.last) begin
      stats_due.push_back(set_statistics());
      clear_set();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic compare_stats(input ssmmv_pkg::result_req_t got);
    ssmmv_pkg::result_req_t want;
    if (stats_due.size() == 0) begin
      $display("%0t: result with no set closed, actual %h", $time, got);
      error_count++;
    end else begin
      want = stats_due.pop_front();
      check_field("max_value", want.max_value, got.max_value);
      check_field("min_value", want.min_value, got.min_value);
      check_field("mean_fixed", want.mean_fixed, got.mean_fixed);
      check_field("variance_fixed", want.variance_fixed, got.variance_fixed);
      check_field("sample_count", want.sample_count, got.sample_count);
      check_field("overflow_error", want.overflow_error, got.overflow_error);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_set();
      stats_due.delete();
      results_pending <= 0;
    end else begin
      if (out_valid && out_ready) compare_stats(out_req);
      if (in_valid && in_ready) absorb_sample(in_req);
      results_pending <= stats_due.size();
    end
  end

endmodule

// ----- dv/sample_set_min_max_mean_variance_test.sv -----
module sample_set_min_max_mean_variance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS  = 1750;
  localparam int STALL_CYCLES = 600;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 300;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  ssmmv_pkg::sample_req_t in_req    = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  ssmmv_pkg::result_req_t out_req;

  int error_count;
  int results_pending;
  int send_idle_pct  = 9;
  int recv_idle_pct  = 54;
  int stall_requests = 0;
  int stalls_served  = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int items_sent     = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sample_set_min_max_mean_variance dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
  );

  sample_set_min_max_mean_variance_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req          (in_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_req         (out_req),
    .error_count     (error_count),
    .results_pending (results_pending)
  );

  // result side, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stalls_served != stall_requests) begin
      out_ready     <= 1'b0;
      hold_left     <= STALL_CYCLES;
      stalls_served <= stall_requests;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sample_set_min_max_mean_variance_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(input logic signed [15:0] value, input logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{sample: value, last: closes};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic signed [15:0] pick_sample(input int mode, input logic [15:0] fixed);
    case (mode)
      0: return fixed;
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2: return 16'($urandom_range(16) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int          set_len;
    int          mode;
    logic [15:0] fixed;
    bit          pressed_early;
    bit          pressed_late;
    pressed_early = 1'b0;
    pressed_late  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // single-sample sets at both extremes
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b1);
    // widest spread
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    // full set of the most negative value, then dropped samples, the last one closing
    repeat (ssmmv_pkg::MAX_COUNT_DEF) push_sample(16'sh8000, 1'b0);
    push_sample(16'sh1234, 1'b0);
    push_sample(16'sh7fff, 1'b1);

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= 1200) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end else if (items_sent >= 620) begin
        send_idle_pct = 54;
        recv_idle_pct <= 9;
      end
      if (!pressed_early && items_sent >= 60) begin
        pressed_early = 1'b1;
        stall_requests <= stall_requests + 1;
      end
      if (!pressed_late && items_sent >= 1300) begin
        pressed_late = 1'b1;
        stall_requests <= stall_requests + 1;
      end
      case ($urandom_range(9))
        0: set_len = ssmmv_pkg::MAX_COUNT_DEF;
        1: set_len = ssmmv_pkg::MAX_COUNT_DEF + $urandom_range(1, 5);
        2: set_len = 1;
        default: set_len = $urandom_range(1, ssmmv_pkg::MAX_COUNT_DEF);
      endcase
      mode  = $urandom_range(7);
      fixed = 16'($urandom);
      for (int i = 0; i < set_len; i++) begin
        push_sample(pick_sample(mode, fixed), i == set_len - 1);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && results_pending == 0) begin
      $display("sample_set_min_max_mean_variance_test: done, clean");
    end else begin
      $display("sample_set_min_max_mean_variance_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ssmmv_pkg.sv
hdl/ssmmv_div.sv
hdl/ssmmv_seq.sv
hdl/sample_set_min_max_mean_variance.sv
hdl/ssmmv_chk.sv
dv/sample_set_min_max_mean_variance_checker.sv
dv/sample_set_min_max_mean_variance_test.sv
